// ----- hw/rtl/deq_pkg.sv -----
// Shared types, codes and defaults for the double-ended queue.
package deq_pkg;

  localparam int WORD_W    = 64;
  localparam int DEPTH_DEF = 16;

  // Operation codes carried in the op field
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REVERSE    = 3'd4,
    OP_QUERY      = 3'd5
  } op_t;

  // Status codes reported with every result
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One incoming command item
  typedef struct packed {
    logic [2:0]        op;
    logic [WORD_W-1:0] value;
  } req_t;

  // One result item
  typedef struct packed {
    logic [WORD_W-1:0] front_value;
    logic [WORD_W-1:0] back_value;
    logic [4:0]        count;
    logic              empty_res;
    logic [1:0]        status;
  } res_t;

  // Result bookkeeping handed from the pointer logic to the output stage
  typedef struct packed {
    logic [4:0] count;
    logic       empty;
    status_t    status;
    logic       rev;
  } res_meta_t;

endpackage

// ----- hw/rtl/deq_ram.sv -----
// Ring store: one write port, two read ports with registered data and write bypass.
module deq_ram import deq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr_a,
  input  logic [AW-1:0]     rd_addr_b,
  output logic [WORD_W-1:0] rd_data_a,
  output logic [WORD_W-1:0] rd_data_b
);

  logic [WORD_W-1:0] mem [DEPTH];

  // Write the pushed word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read both ends; forward a word written in the same cycle
  always_ff @(posedge clk) begin
    rd_data_a <= (wr_en && wr_addr == rd_addr_a) ? wr_data : mem[rd_addr_a];
    rd_data_b <= (wr_en && wr_addr == rd_addr_b) ? wr_data : mem[rd_addr_b];
  end

endmodule

// ----- hw/rtl/deq_ctrl.sv -----
// Pointer, occupancy and direction logic of the double-ended queue.
module deq_ctrl import deq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [2:0]    in_op,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [AW-1:0] rd_head,
  output logic [AW-1:0] rd_tail,
  output logic          res_valid,
  output res_meta_t     meta
);

  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [CW-1:0] occ, occ_next;
  logic          rev, rev_next;
  status_t       status_next;
  logic          full, empty, phys_front;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] x);
    return (x == LAST_IDX) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] x);
    return (x == '0) ? LAST_IDX : x - 1'b1;
  endfunction

  assign full  = (occ == FULL_CNT);
  assign empty = (occ == '0);

  // Decode the operation and compute the next pointers
  always_comb begin
    head_next   = head;
    tail_next   = tail;
    occ_next    = occ;
    rev_next    = rev;
    status_next = ST_DONE;
    wr_en       = 1'b0;
    wr_addr     = head;
    phys_front  = 1'b0;
    if (in_valid) begin
      case (in_op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          phys_front = (in_op == OP_PUSH_FRONT) != rev;
          if (full) begin
            status_next = ST_FULL;
          end else begin
            wr_en    = 1'b1;
            occ_next = occ + 1'b1;
            if (phys_front) begin
              head_next = idx_dec(head);
              wr_addr   = head_next;
            end else begin
              tail_next = idx_inc(tail);
              wr_addr   = tail_next;
            end
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          phys_front = (in_op == OP_POP_FRONT) != rev;
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            occ_next = occ - 1'b1;
            if (phys_front) begin
              head_next = idx_inc(head);
            end else begin
              tail_next = idx_dec(tail);
            end
          end
        end
        OP_REVERSE: begin
          rev_next = ~rev;
        end
        default: begin
          // query and unused codes leave the state alone
        end
      endcase
    end
  end

  assign rd_head = head_next;
  assign rd_tail = tail_next;

  // Hold queue state; tail sits one behind head when empty
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= LAST_IDX;
      occ       <= '0;
      rev       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      head      <= head_next;
      tail      <= tail_next;
      occ       <= occ_next;
      rev       <= rev_next;
      res_valid <= in_valid;
    end
  end

  // Capture result bookkeeping alongside the read data
  always_ff @(posedge clk) begin
    if (in_valid) begin
      meta.count  <= 5'(occ_next);
      meta.empty  <= (occ_next == '0);
      meta.status <= status_next;
      meta.rev    <= rev_next;
    end
  end

  // Expected tail position from head and occupancy
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail_exp;
  assign tail_sum = {1'b0, head} + (AW+1)'(occ) - 1'b1;
  assign tail_exp = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                 : tail_sum[AW-1:0];

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= FULL_CNT)
    else $error("occupancy above depth");

  a_tail_track: assert property (@(posedge clk) disable iff (rst)
    (occ != '0) |-> (tail == tail_exp))
    else $error("tail pointer out of step with head and occupancy");

  a_refused_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && status_next != ST_DONE) |=> ($stable(occ) && $stable(head) && $stable(tail)))
    else $error("refused operation changed queue state");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (occ < FULL_CNT))
    else $error("write issued into a full store");

endmodule

// ----- hw/rtl/double_ended_queue.sv -----
// Top level of the double-ended queue: command register, pointer logic, ring store, result.
//
// The block takes one command item on every clock cycle: busy stays low, and each
// accepted item yields exactly one result on the result port, marked by done once the
// item has passed the command register and then the registered result stage. Results
// stream out at one per cycle in command order, and the receiver cannot stall them.
// The rate is set by the single pass through the pointer update and the two-port ring
// store, whose read data is registered together with the result fields. The store
// needs no clearing after reset; front_value and back_value read 0 while the queue is empty.
module double_ended_queue import deq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output res_t result
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic              req_valid;
  req_t              req;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_head;
  logic [AW-1:0]     rd_tail;
  logic [WORD_W-1:0] head_word;
  logic [WORD_W-1:0] tail_word;
  logic              res_valid;
  res_meta_t         meta;

  assign busy = 1'b0;

  // Register the incoming command item
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      req <= request;
    end
  end

  deq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_op     (req.op),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .rd_head   (rd_head),
    .rd_tail   (rd_tail),
    .res_valid (res_valid),
    .meta      (meta)
  );

  deq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (req.value),
    .rd_addr_a (rd_head),
    .rd_addr_b (rd_tail),
    .rd_data_a (head_word),
    .rd_data_b (tail_word)
  );

  // Map physical ends to logical front and back
  assign done               = res_valid;
  assign result.front_value = meta.empty ? '0 : (meta.rev ? tail_word : head_word);
  assign result.back_value  = meta.empty ? '0 : (meta.rev ? head_word : tail_word);
  assign result.count       = meta.count;
  assign result.empty_res   = meta.empty;
  assign result.status      = meta.status;

endmodule
